[hdl/hcl_pkg.sv]
// Shared constants, result burst type and hex decode helpers for the
// hex color line parser. No dependencies.
package hcl_pkg;

  localparam int LINE_MAX    = 255;
  localparam int STORE_DEPTH = 7;
  localparam int CNT_W       = 8;
  localparam int IDX_W       = $clog2(STORE_DEPTH);

  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TILDE = 8'd126;
  localparam logic [7:0] CH_DEL   = 8'd127;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_D0    = 8'd48;
  localparam logic [7:0] CH_D9    = 8'd57;
  localparam logic [7:0] CH_UA    = 8'd65;
  localparam logic [7:0] CH_UF    = 8'd70;
  localparam logic [7:0] CH_LA    = 8'd97;
  localparam logic [7:0] CH_LF    = 8'd102;

  // Burst kinds: what one accepted byte asks the transmitter to send
  localparam logic [1:0] KIND_ECHO  = 2'd0;
  localparam logic [1:0] KIND_ERASE = 2'd1;
  localparam logic [1:0] KIND_EOL   = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD_HEX = 2'd1;
  localparam logic [1:0] STATUS_BAD_LEN = 2'd2;
  localparam logic [1:0] STATUS_NO_HASH = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic       color_valid;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] status;
  } burst_t;

  // Returns {ok, nibble}
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] res;
    res = 5'd0;
    if (c >= CH_D0 && c <= CH_D9) begin
      res = {1'b1, c[3:0]};
    end else if ((c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF)) begin
      res = {1'b1, c[3:0] + 4'd9};
    end
    return res;
  endfunction

  // Returns {bad, value}; value is 255 for a bad pair
  function automatic logic [8:0] hex_pair(input logic [7:0] hi, input logic [7:0] lo);
    logic [4:0] h;
    logic [4:0] l;
    logic [8:0] res;
    h = hex_nibble(hi);
    l = hex_nibble(lo);
    if (h[4] && l[4]) begin
      res = {1'b0, h[3:0], l[3:0]};
    end else begin
      res = {1'b1, 8'hFF};
    end
    return res;
  endfunction

endpackage

[hdl/hcl_if.sv]
// Valid/ready channel interfaces for the hex color line parser:
// received bytes in, transmit results out. No dependencies.
interface hcl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hcl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       line_done;
  logic       color_valid;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output tx_byte, output line_done, output color_valid,
                  output red, output green, output blue, output status, output last,
                  input ready);
  modport sink   (input valid, input tx_byte, input line_done, input color_valid,
                  input red, input green, input blue, input status, input last,
                  output ready);
endinterface

[hdl/hex_color_line_parser_core.sv]
// Serial command-line editor with #RRGGBB color decode. A received byte is
// accepted in any cycle in which the burst register is free or being
// handed on, so bytes may arrive back to back. Each printable byte yields one
// echo request, DEL on a non-empty line yields three (BS, space, BS), CR
// yields two (CR, then LF carrying line_done, color and status); other bytes
// are dropped with no request. The serializer sends one request per cycle
// that the sink is ready, and a new byte can be taken while an earlier
// burst is still going out. Line storage needs no clearing after reset.
// Depends on hcl_pkg, hcl_if, hcl_editor, hcl_serializer.
module hex_color_line_parser_core
  import hcl_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  hcl_in_if.sink        in_ch,
  hcl_out_if.source     out_ch
);

  burst_t burst;
  logic   burst_vld;
  logic   burst_take;

  hcl_editor u_editor (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .burst      (burst),
    .burst_vld  (burst_vld),
    .burst_take (burst_take)
  );

  hcl_serializer u_serializer (
    .clk        (clk),
    .rst_n      (rst_n),
    .burst      (burst),
    .burst_vld  (burst_vld),
    .burst_take (burst_take),
    .out_ch     (out_ch)
  );

  // A pending burst holds until the serializer takes it
  a_burst_hold: assert property (@(posedge clk) disable iff (!rst_n)
    burst_vld && !burst_take |=> burst_vld && $stable(burst))
    else $error("pending burst changed before hand-off");

  // Requests of one burst go out without gaps
  a_burst_contig: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.last |=> out_ch.valid)
    else $error("gap inside a result burst");

  // Color only on the closing request of a line
  a_color_eol: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.color_valid || out_ch.status != STATUS_OK) |->
      out_ch.line_done && out_ch.last)
    else $error("line fields outside the line-feed request");

endmodule

[hdl/hcl_editor.sv]
// Line editor: keeps the character count and first characters of the line, decodes each accepted
// printable, line-end or non-empty-line erase byte into one result burst. Depends on hcl_pkg, hcl_if.
module hcl_editor
  import hcl_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  hcl_in_if.sink        in_ch,
  output burst_t        burst,
  output logic          burst_vld,
  input  logic          burst_take
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       chars_r [STORE_DEPTH];
  burst_t           burst_r, burst_nxt;
  logic             burst_vld_r, burst_vld_nxt;

  logic       acc;
  logic       printable, is_del, is_cr;
  logic [CNT_W:0] count_inc;
  logic [8:0] pair_red, pair_grn, pair_blu;
  logic       len_ok, hash_ok;

  assign in_ch.ready = !burst_vld_r || burst_take;
  assign acc         = in_ch.valid && in_ch.ready;

  assign printable = (in_ch.rx_byte >= CH_SPACE) && (in_ch.rx_byte <= CH_TILDE);
  assign is_del    = (in_ch.rx_byte == CH_DEL);
  assign is_cr     = (in_ch.rx_byte == CH_CR);
  assign count_inc = {1'b0, count_r} + {{CNT_W{1'b0}}, 1'b1};

  assign len_ok   = (count_r == CNT_W'(STORE_DEPTH));
  assign hash_ok  = (chars_r[0] == CH_HASH);
  assign pair_red = hex_pair(chars_r[1], chars_r[2]);
  assign pair_grn = hex_pair(chars_r[3], chars_r[4]);
  assign pair_blu = hex_pair(chars_r[5], chars_r[6]);

  always_comb begin
    count_nxt     = count_r;
    burst_nxt     = burst_r;
    burst_vld_nxt = burst_vld_r && !burst_take;
    if (acc) begin
      if (printable) begin
        count_nxt = (count_inc >= (CNT_W+1)'(LINE_MAX)) ? '0 : count_inc[CNT_W-1:0];
        burst_nxt = '0;
        burst_nxt.kind = KIND_ECHO;
        burst_nxt.ch   = in_ch.rx_byte;
        burst_vld_nxt  = 1'b1;
      end else if (is_del && count_r != '0) begin
        count_nxt = count_r - CNT_W'(1);
        burst_nxt = '0;
        burst_nxt.kind = KIND_ERASE;
        burst_vld_nxt  = 1'b1;
      end else if (is_cr) begin
        count_nxt = '0;
        burst_nxt = '0;
        burst_nxt.kind = KIND_EOL;
        if (!len_ok) begin
          burst_nxt.status = STATUS_BAD_LEN;
        end else if (!hash_ok) begin
          burst_nxt.status = STATUS_NO_HASH;
        end else begin
          burst_nxt.color_valid = 1'b1;
          burst_nxt.red   = pair_red[7:0];
          burst_nxt.green = pair_grn[7:0];
          burst_nxt.blue  = pair_blu[7:0];
          burst_nxt.status = (pair_red[8] || pair_grn[8] || pair_blu[8]) ?
                             STATUS_BAD_HEX : STATUS_OK;
        end
        burst_vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      burst_vld_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      burst_vld_r <= burst_vld_nxt;
    end
  end

  // Payload: line storage keeps only the first characters
  always_ff @(posedge clk) begin
    burst_r <= burst_nxt;
    if (acc && printable && count_r < CNT_W'(STORE_DEPTH)) begin
      chars_r[count_r[IDX_W-1:0]] <= in_ch.rx_byte;
    end
  end

  assign burst     = burst_r;
  assign burst_vld = burst_vld_r;

endmodule

[hdl/hcl_serializer.sv]
// Result serializer: plays one burst out as one, two or three result
// requests on the output channel. Depends on hcl_pkg, hcl_if.
module hcl_serializer
  import hcl_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  burst_t        burst,
  input  logic          burst_vld,
  output logic          burst_take,
  hcl_out_if.source     out_ch
);

  burst_t     cur_r;
  logic       cur_vld_r;
  logic [1:0] idx_r;
  logic       last_item;
  logic       eol_item;

  always_comb begin
    unique case (cur_r.kind)
      KIND_ECHO:  last_item = 1'b1;
      KIND_ERASE: last_item = (idx_r == 2'd2);
      KIND_EOL:   last_item = (idx_r == 2'd1);
      default:    last_item = 1'b1;
    endcase
  end

  assign eol_item   = (cur_r.kind == KIND_EOL) && (idx_r == 2'd1);
  assign burst_take = !cur_vld_r || (out_ch.ready && last_item);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      idx_r     <= '0;
    end else if (burst_take) begin
      cur_vld_r <= burst_vld;
      idx_r     <= '0;
    end else if (out_ch.ready) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (burst_take) begin
      cur_r <= burst;
    end
  end

  always_comb begin
    unique case (cur_r.kind)
      KIND_ECHO:  out_ch.tx_byte = cur_r.ch;
      KIND_ERASE: out_ch.tx_byte = (idx_r == 2'd1) ? CH_SPACE : CH_BS;
      KIND_EOL:   out_ch.tx_byte = (idx_r == 2'd0) ? CH_CR : CH_NL;
      default:    out_ch.tx_byte = cur_r.ch;
    endcase
  end

  // Line fields ride only on the line-feed request
  assign out_ch.valid       = cur_vld_r;
  assign out_ch.last        = last_item;
  assign out_ch.line_done   = eol_item;
  assign out_ch.color_valid = eol_item && cur_r.color_valid;
  assign out_ch.red         = eol_item ? cur_r.red   : 8'd0;
  assign out_ch.green       = eol_item ? cur_r.green : 8'd0;
  assign out_ch.blue        = eol_item ? cur_r.blue  : 8'd0;
  assign out_ch.status      = eol_item ? cur_r.status : STATUS_OK;

endmodule

[verif/hcl_check_pkg.sv]
// Result type, hex decode and line-editor scoreboard for the testbench of
// the hex color line parser. Depends on hcl_pkg.
package hcl_check_pkg;
  import hcl_pkg::*;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       line_done;
    logic       color_valid;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] status;
    logic       last;
  } tx_result_t;

  // Value of one hex digit, or -1 when the byte is not one
  function automatic int hex_value(input logic [7:0] c);
    if (c >= CH_D0 && c <= CH_D9) return int'(c) - int'(CH_D0);
    if (c >= CH_UA && c <= CH_UF) return int'(c) - int'(CH_UA) + 10;
    if (c >= CH_LA && c <= CH_LF) return int'(c) - int'(CH_LA) + 10;
    return -1;
  endfunction

  class line_scoreboard;
    logic [7:0] line_buf [STORE_DEPTH];
    logic [7:0] char_cnt;
    tx_result_t expected_q [$];
    int         errors;

    function new();
      foreach (line_buf[i]) line_buf[i] = '0;
      char_cnt = '0;
      errors   = 0;
    endfunction

    function void push_plain(input logic [7:0] tx, input bit last);
      tx_result_t r;
      r         = '0;
      r.tx_byte = tx;
      r.last    = last;
      expected_q.push_back(r);
    endfunction

    function logic [7:0] color_byte(input logic [7:0] hi, input logic [7:0] lo,
                                    inout bit bad);
      int h;
      int l;
      h = hex_value(hi);
      l = hex_value(lo);
      if (h < 0 || l < 0) begin
        bad = 1'b1;
        return 8'hFF;
      end
      return 8'(h * 16 + l);
    endfunction

    // Update the line state for one accepted request; return results queued
    function int note_request(input logic [7:0] rx);
      tx_result_t eol;
      bit         bad;
      int         queued;
      queued = expected_q.size();
      if (rx >= CH_SPACE && rx <= CH_TILDE) begin
        if (char_cnt < 8'(STORE_DEPTH)) line_buf[char_cnt[IDX_W-1:0]] = rx;
        char_cnt = char_cnt + 8'd1;
        // restart a full line without notice
        if (char_cnt >= 8'(LINE_MAX)) char_cnt = '0;
        push_plain(rx, 1'b1);
      end else if (rx == CH_DEL) begin
        if (char_cnt != '0) begin
          char_cnt = char_cnt - 8'd1;
          push_plain(CH_BS, 1'b0);
          push_plain(CH_SPACE, 1'b0);
          push_plain(CH_BS, 1'b1);
        end
      end else if (rx == CH_CR) begin
        push_plain(CH_CR, 1'b0);
        eol           = '0;
        eol.tx_byte   = CH_NL;
        eol.line_done = 1'b1;
        eol.last      = 1'b1;
        if (char_cnt != 8'(STORE_DEPTH)) begin
          eol.status = STATUS_BAD_LEN;
        end else if (line_buf[0] != CH_HASH) begin
          eol.status = STATUS_NO_HASH;
        end else begin
          bad             = 1'b0;
          eol.red         = color_byte(line_buf[1], line_buf[2], bad);
          eol.green       = color_byte(line_buf[3], line_buf[4], bad);
          eol.blue        = color_byte(line_buf[5], line_buf[6], bad);
          eol.color_valid = 1'b1;
          eol.status      = bad ? STATUS_BAD_HEX : STATUS_OK;
        end
        expected_q.push_back(eol);
        char_cnt = '0;
      end
      return expected_q.size() - queued;
    endfunction

    function void compare_field(input string name, input logic [7:0] exp_v,
                                input logic [7:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(input tx_result_t got);
      tx_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("unexpected result: tx_byte %0d with nothing pending", got.tx_byte);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      compare_field("tx_byte", exp_r.tx_byte, got.tx_byte);
      compare_field("line_done", 8'(exp_r.line_done), 8'(got.line_done));
      compare_field("color_valid", 8'(exp_r.color_valid), 8'(got.color_valid));
      compare_field("red", exp_r.red, got.red);
      compare_field("green", exp_r.green, got.green);
      compare_field("blue", exp_r.blue, got.blue);
      compare_field("status", 8'(exp_r.status), 8'(got.status));
      compare_field("last", 8'(exp_r.last), 8'(got.last));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

[verif/hex_color_line_parser_core_tb.sv]
// Testbench top for hex_color_line_parser_core: drives received bytes,
// checks every transmit result against the line scoreboard.
// Depends on hcl_pkg, hcl_if, hcl_check_pkg and the core.
module hex_color_line_parser_core_tb;
  import hcl_pkg::*;
  import hcl_check_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int TAIL_CYCLES  = 20;
  localparam int PHASE_ITEMS  = 50;

  logic        clk;
  logic        rst_n;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          result_items  = 0;
  int unsigned cycle_cnt     = 0;
  line_scoreboard sb;

  hcl_in_if  in_ch ();
  hcl_out_if out_ch ();

  hex_color_line_parser_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: sample at the rising edge, check and move ready at the falling one
  initial begin
    tx_result_t got;
    bit         hs;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      hs              = (out_ch.valid === 1'b1) && (out_ch.ready === 1'b1);
      got.tx_byte     = out_ch.tx_byte;
      got.line_done   = out_ch.line_done;
      got.color_valid = out_ch.color_valid;
      got.red         = out_ch.red;
      got.green       = out_ch.green;
      got.blue        = out_ch.blue;
      got.status      = out_ch.status;
      got.last        = out_ch.last;
      @(negedge clk);
      if (hs) sb.check_result(got);
      out_ch.ready <= (rst_n === 1'b1) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    if (sb.note_request(b) > 0) result_items++;
    @(negedge clk);
  endtask

  // Hold off until every pending request has been answered
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_printable();
    return 8'($urandom_range(126, 32));
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int v;
    v = $urandom_range(15);
    if (v < 10) return 8'(int'(CH_D0) + v);
    return 8'(int'($urandom_range(1) ? CH_LA : CH_UA) + v - 10);
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] c;
    do c = rand_printable(); while (hex_value(c) >= 0);
    return c;
  endfunction

  // Color line with random digits, at times a non-hex one, typos erased and retyped
  task automatic send_color_line();
    logic [7:0] c;
    send_byte(CH_HASH);
    for (int i = 0; i < 6; i++) begin
      c = ($urandom_range(9) == 0) ? rand_non_hex() : rand_hex_char();
      if ($urandom_range(5) == 0) begin
        send_byte(rand_printable());
        send_byte(CH_DEL);
      end
      send_byte(c);
    end
    if ($urandom_range(3) == 0) begin
      send_byte(rand_printable());
      send_byte(CH_DEL);
    end
    send_byte(CH_CR);
  endtask

  task automatic send_unhashed_line();
    logic [7:0] c;
    do c = rand_printable(); while (c == CH_HASH);
    send_byte(c);
    repeat (6) send_byte(rand_hex_char());
    send_byte(CH_CR);
  endtask

  task automatic send_odd_length_line();
    int len;
    len = $urandom_range(12);
    if (len == STORE_DEPTH) len++;
    repeat (len) send_byte(rand_printable());
    send_byte(CH_CR);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(4, 1)) begin
      case ($urandom_range(3))
        0: send_byte(8'($urandom_range(31)));
        1: send_byte(8'($urandom_range(255, 128)));
        2: send_byte(CH_DEL);
        default: send_byte(8'($urandom_range(255)));
      endcase
    end
  endtask

  task automatic run_phase(input int s_idle, input int r_idle);
    int start;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    start = result_items;
    while (result_items - start < PHASE_ITEMS) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: send_color_line();
        5: send_odd_length_line();
        6: send_unhashed_line();
        default: send_noise();
      endcase
      if ($urandom_range(7) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    sb            = new();
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ignored bytes, empty-line erase, printable extremes, erase, CR, two color lines
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_DEL);
    send_byte(CH_SPACE);
    send_byte(CH_TILDE);
    send_byte(CH_DEL);
    send_byte(CH_CR);
    send_text("#aF09Bc");
    send_byte(CH_CR);
    send_text("#0g12F9");
    send_byte(CH_CR);
    wait_drained();

    run_phase(32, 80);
    run_phase(80, 32);
    run_phase(0, 0);

    // fill the line to its limit so it restarts, then a color line after it
    send_byte(CH_CR);
    repeat (LINE_MAX) send_byte(rand_printable());
    send_color_line();
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
